>>> design/salc_pkg.sv
package salc_pkg;

  localparam int MAX_BLOCKS      = 2048;
  localparam int MAX_WAYS        = 8;
  localparam int BLOCK_BYTES     = 64;
  localparam int ADDR_BITS       = 32;

  localparam int BLOCKS_LOG2     = $clog2(MAX_BLOCKS);
  localparam int WAYS_LOG2       = $clog2(MAX_WAYS);
  localparam int OFFSET_BITS     = $clog2(BLOCK_BYTES);
  localparam int TAG_BITS        = ADDR_BITS - OFFSET_BITS;
  localparam int STAMP_BITS      = 32;
  localparam int COUNT_BITS      = 32;
  localparam int ROWS            = MAX_BLOCKS / MAX_WAYS;
  localparam int ROW_ADDR_BITS   = BLOCKS_LOG2 - WAYS_LOG2;
  localparam int SL_W            = 4;
  localparam int WL_W            = 2;
  localparam int CFG_DATA_W      = 4;
  localparam int CFG_INDEX_W     = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SETS_LOG2 = 1'b0,
    CFG_WAYS_LOG2 = 1'b1
  } cfg_index_t;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] byte_address;
  } salc_in_t;

  typedef struct packed {
    logic                  hit;
    logic [2:0]            way_used;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
  } salc_out_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]   valid;
    entry_t [MAX_WAYS-1:0] entry;
  } row_t;

  typedef struct packed {
    logic                 hit;
    logic [WAYS_LOG2-1:0] way;
  } sel_t;

endpackage

>>> design/salc_tag_ram.sv
module salc_tag_ram import salc_pkg::*; (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [ROW_ADDR_BITS-1:0] rd_addr,
  output row_t                     rd_data,
  input  logic                     wr_en,
  input  logic [ROW_ADDR_BITS-1:0] wr_addr,
  input  row_t                     wr_data
);

  row_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/salc_way_select.sv
module salc_way_select import salc_pkg::*; (
  input  row_t                  row_data,
  input  logic [TAG_BITS-1:0]   tag,
  input  logic [WAYS_LOG2-1:0]  lane_base,
  input  logic [WL_W-1:0]       wl,
  input  logic [STAMP_BITS-1:0] stamp,
  output sel_t                  sel
);

  typedef struct packed {
    logic                  ok;
    logic [STAMP_BITS-1:0] age;
    logic [WAYS_LOG2-1:0]  idx;
  } cand_t;

  function automatic cand_t pick(input cand_t a, input cand_t b);
    pick = (b.ok && (b.age > a.age)) ? b : a;
  endfunction

  logic [MAX_WAYS-1:0]  in_set;
  logic [MAX_WAYS-1:0]  match;
  logic [MAX_WAYS-1:0]  free;
  logic [WAYS_LOG2-1:0] hit_way;
  logic [WAYS_LOG2-1:0] free_way;
  logic [WAYS_LOG2-1:0] lane;
  cand_t                cand [MAX_WAYS];
  cand_t                lvl1 [MAX_WAYS/2];
  cand_t                lvl2 [MAX_WAYS/4];
  cand_t                best;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      lane       = lane_base | WAYS_LOG2'(w);
      in_set[w]  = (WAYS_LOG2'(w) >> wl) == '0;
      match[w]   = in_set[w] && row_data.valid[lane] && (row_data.entry[lane].tag == tag);
      free[w]    = in_set[w] && !row_data.valid[lane];
      cand[w].ok  = in_set[w];
      cand[w].age = stamp - row_data.entry[lane].stamp;
      cand[w].idx = WAYS_LOG2'(w);
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAYS_LOG2'(w);
      end
      if (free[w]) begin
        free_way = WAYS_LOG2'(w);
      end
    end
    // oldest way, ties to the lower way
    for (int i = 0; i < MAX_WAYS / 2; i++) begin
      lvl1[i] = pick(cand[2*i], cand[2*i+1]);
    end
    for (int i = 0; i < MAX_WAYS / 4; i++) begin
      lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    best = pick(lvl2[0], lvl2[1]);

    sel.hit = |match;
    if (|match) begin
      sel.way = hit_way;
    end else if (|free) begin
      sel.way = free_way;
    end else begin
      sel.way = best.idx;
    end
  end

endmodule

>>> design/set_assoc_lru_cache_tags_top.sv
// Tag store of a set-associative cache (64-byte blocks, up to 2048 blocks, 1 to 8 ways)
// with LRU replacement and saturating hit and miss counters. Each input word is an
// access or a flush and gives exactly one result word. The set's row is read from the
// tag RAM at acceptance, then compared, updated and written back in the update state
// once the output register is free, so no new word is taken until that is done. A new
// word is taken while the previous result waits in the output register. Per-row valid
// flops make reset and flush take effect at once; there is no clearing pass. The user
// must write sets_log2 and ways_log2 only while idle; the block does not enforce it. A
// geometry with more than 2048 blocks is clamped by reducing the set count.
module set_assoc_lru_cache_tags_top import salc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  salc_in_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output salc_out_t              out_word
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  state_t                    state;
  state_t                    state_next;
  logic [SL_W-1:0]           sets_log2;
  logic [WL_W-1:0]           ways_log2;
  logic [ROWS-1:0]           row_valid;
  logic [STAMP_BITS-1:0]     access_stamp;
  logic [COUNT_BITS-1:0]     hit_counter;
  logic [COUNT_BITS-1:0]     miss_counter;

  logic                      b_op;
  logic [TAG_BITS-1:0]       b_tag;
  logic [WAYS_LOG2-1:0]      b_lane_base;
  logic [WL_W-1:0]           b_wl;
  logic [ROW_ADDR_BITS-1:0]  b_row;
  logic                      b_row_valid;

  logic                      in_accept;
  logic                      update;
  logic [SL_W:0]             geo_sum;
  logic [SL_W-1:0]           sl_eff;
  logic [TAG_BITS-1:0]       block;
  logic [BLOCKS_LOG2-1:0]    set_mask;
  logic [BLOCKS_LOG2-1:0]    set_idx;
  logic [BLOCKS_LOG2-1:0]    base;
  logic [TAG_BITS-1:0]       acc_tag;

  row_t                      rd_row;
  row_t                      cur_row;
  row_t                      new_row;
  sel_t                      sel;
  logic [WAYS_LOG2-1:0]      lane;
  logic                      wr_en;
  logic [COUNT_BITS-1:0]     hit_counter_next;
  logic [COUNT_BITS-1:0]     miss_counter_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign update    = (state == ST_UPDATE) && (!out_valid || !out_stall);

  // way count always fits MAX_WAYS and MAX_BLOCKS; only the set count is clamped
  always_comb begin
    geo_sum = {1'b0, sets_log2} + (SL_W+1)'(ways_log2);
    if (geo_sum > (SL_W+1)'(BLOCKS_LOG2)) begin
      sl_eff = SL_W'(BLOCKS_LOG2) - SL_W'(ways_log2);
    end else begin
      sl_eff = sets_log2;
    end
    block    = in_word.byte_address[ADDR_BITS-1:OFFSET_BITS];
    set_mask = ~({BLOCKS_LOG2{1'b1}} << sl_eff);
    set_idx  = block[BLOCKS_LOG2-1:0] & set_mask;
    acc_tag  = block >> sl_eff;
    base     = set_idx << ways_log2;
  end

  salc_tag_ram u_tag_ram (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (base[BLOCKS_LOG2-1:WAYS_LOG2]),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (b_row),
    .wr_data (new_row)
  );

  always_comb begin
    cur_row = rd_row;
    if (!b_row_valid) begin
      cur_row.valid = '0;
    end
  end

  salc_way_select u_way_select (
    .row_data  (cur_row),
    .tag       (b_tag),
    .lane_base (b_lane_base),
    .wl        (b_wl),
    .stamp     (access_stamp),
    .sel       (sel)
  );

  always_comb begin
    lane                     = b_lane_base | sel.way;
    new_row                  = cur_row;
    new_row.valid[lane]      = 1'b1;
    new_row.entry[lane].tag  = b_tag;
    new_row.entry[lane].stamp = access_stamp;
    wr_en                    = update && (b_op == OP_ACCESS);
    hit_counter_next         = sel.hit ? sat_inc(hit_counter) : hit_counter;
    miss_counter_next        = sel.hit ? miss_counter : sat_inc(miss_counter);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (update) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sets_log2    <= SL_W'(4);
      ways_log2    <= '0;
      row_valid    <= '0;
      access_stamp <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETS_LOG2: sets_log2 <= cfg_data[SL_W-1:0];
          CFG_WAYS_LOG2: ways_log2 <= cfg_data[WL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (update) begin
        out_valid <= 1'b1;
        if (b_op == OP_FLUSH) begin
          row_valid    <= '0;
          access_stamp <= '0;
          hit_counter  <= '0;
          miss_counter <= '0;
        end else begin
          row_valid[b_row] <= 1'b1;
          access_stamp     <= access_stamp + STAMP_BITS'(1);
          hit_counter      <= hit_counter_next;
          miss_counter     <= miss_counter_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_op        <= in_word.op;
      b_tag       <= acc_tag;
      b_lane_base <= base[WAYS_LOG2-1:0];
      b_wl        <= ways_log2;
      b_row       <= base[BLOCKS_LOG2-1:WAYS_LOG2];
      b_row_valid <= row_valid[base[BLOCKS_LOG2-1:WAYS_LOG2]];
    end
    if (update) begin
      if (b_op == OP_FLUSH) begin
        out_word <= '0;
      end else begin
        out_word.hit        <= sel.hit;
        out_word.way_used   <= sel.way;
        out_word.hit_total  <= hit_counter_next;
        out_word.miss_total <= miss_counter_next;
      end
    end
  end

endmodule

>>> design/salc_checker.sv
module salc_checker import salc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input salc_out_t out_word
);

  // one word in flight: stall right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // a new result only appears after an item was held in the update cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a preceding item");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.hit |-> out_word.hit_total != '0)
    else $error("hit reported with zero hit count");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

endmodule

bind set_assoc_lru_cache_tags_top salc_checker u_salc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

>>> test/tb_set_assoc_lru_cache_tags_top.sv
`timescale 1ns / 100ps
module tb_set_assoc_lru_cache_tags_top;
  import salc_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 120;
  localparam int POOL_SIZE  = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_LIGHT
  } stall_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  salc_in_t               in_word   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  salc_out_t              out_word;

  set_assoc_lru_cache_tags_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // predicted tag store
  logic [SL_W-1:0]       cur_sets_log2 = 4;
  logic [WL_W-1:0]       cur_ways_log2 = 0;
  bit                    line_valid [MAX_BLOCKS];
  logic [TAG_BITS-1:0]   line_tag   [MAX_BLOCKS];
  logic [STAMP_BITS-1:0] line_stamp [MAX_BLOCKS];
  logic [STAMP_BITS-1:0] access_count = '0;
  logic [COUNT_BITS-1:0] hit_count    = '0;
  logic [COUNT_BITS-1:0] miss_count   = '0;

  salc_in_t            pending_words[$];
  salc_out_t           expected_results[$];
  salc_out_t           head_result;
  logic [TAG_BITS-1:0] tag_pool [POOL_SIZE];

  int error_count    = 0;
  int words_accepted = 0;
  int flushes_sent   = 0;
  int results_seen   = 0;
  int hits_seen      = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  int holds_done     = 0;
  int next_hold_at   = 800;
  int pattern_left   = 0;
  int rx_cycles      = 0;
  stall_mode_t stall_mode = STALL_NONE;

  function automatic int unsigned eff_sets_log2(int unsigned sl, int unsigned wl);
    return (sl + wl > BLOCKS_LOG2) ? BLOCKS_LOG2 - wl : sl;
  endfunction

  function automatic salc_out_t lookup_and_fill(salc_in_t w);
    salc_out_t             r;
    int unsigned           sl, nways, base, e, k;
    logic [TAG_BITS-1:0]   blk, tg;
    int                    found, victim;
    logic [STAMP_BITS-1:0] age, best_age;
    r = '0;
    found = -1;
    victim = -1;
    best_age = '0;
    if (w.op == OP_FLUSH) begin
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      hit_count = '0;
      miss_count = '0;
      access_count = '0;
      return r;
    end
    sl = eff_sets_log2(cur_sets_log2, cur_ways_log2);
    nways = 1 << cur_ways_log2;
    blk = w.byte_address[ADDR_BITS-1:OFFSET_BITS];
    tg = blk >> sl;
    base = (blk & ((1 << sl) - 1)) * nways;
    for (k = 0; k < nways; k++) begin
      if (found < 0 && line_valid[base + k] && line_tag[base + k] == tg) found = k;
    end
    if (found >= 0) begin
      line_stamp[base + found] = access_count;
      if (hit_count != '1) hit_count = hit_count + 1;
      r.hit = 1'b1;
      r.way_used = found[2:0];
    end else begin
      for (k = 0; k < nways; k++) begin
        if (victim < 0 && !line_valid[base + k]) victim = k;
      end
      if (victim < 0) begin
        for (k = 0; k < nways; k++) begin
          age = access_count - line_stamp[base + k];
          if (k == 0 || age > best_age) begin
            best_age = age;
            victim = k;
          end
        end
      end
      e = base + victim;
      line_valid[e] = 1'b1;
      line_tag[e] = tg;
      line_stamp[e] = access_count;
      if (miss_count != '1) miss_count = miss_count + 1;
      r.hit = 1'b0;
      r.way_used = victim[2:0];
    end
    access_count = access_count + 1;
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  // mostly reuses a few tags on a few sets so that hits and LRU evictions happen
  function automatic salc_in_t random_word();
    salc_in_t            w;
    int unsigned         sl, nsets, nways, set_idx;
    logic [TAG_BITS-1:0] blk;
    sl = eff_sets_log2(cur_sets_log2, cur_ways_log2);
    nsets = 1 << sl;
    nways = 1 << cur_ways_log2;
    w.op = OP_ACCESS;
    w.byte_address = $urandom;
    if ($urandom_range(0, 99) < 3) begin
      w.op = OP_FLUSH;
    end else if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 4) == 0) set_idx = $urandom_range(0, nsets - 1);
      else set_idx = $urandom_range(0, (nsets < 4) ? nsets - 1 : 3);
      blk = TAG_BITS'((tag_pool[$urandom_range(0, nways + 1)] << sl) | set_idx);
      w.byte_address = {blk, w.byte_address[OFFSET_BITS-1:0]};
    end
    return w;
  endfunction

  task automatic send(logic op, logic [ADDR_BITS-1:0] addr);
    salc_in_t w;
    w.op = op;
    w.byte_address = addr;
    pending_words = {pending_words, w};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SETS_LOG2) cur_sets_log2 = val;
    else cur_ways_log2 = val[WL_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, lookup_and_fill(in_word)};
        words_accepted++;
        if (in_word.op == OP_FLUSH) flushes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with occasional long hold while the sender is busy
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && rx_cycles >= next_hold_at && in_valid) begin
      holds_done++;
      next_hold_at = rx_cycles + 1500;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(8, 60);
      end else begin
        pattern_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_HALF:  out_stall <= $urandom_range(0, 1);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
    if (!rst) rx_cycles++;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_word.hit) hits_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: expected none, got %p", $time, out_word);
      end else begin
        head_result = expected_results.pop_front();
        check_field("hit", head_result.hit, out_word.hit);
        check_field("way_used", head_result.way_used, out_word.way_used);
        check_field("hit_total", head_result.hit_total, out_word.hit_total);
        check_field("miss_total", head_result.miss_total, out_word.miss_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words still due", $time, idle_cycles,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sl_list [8];
    int unsigned wl_list [8];
    sl_list = '{0, 11, 2, 11, 0, 5, 9, 4};
    wl_list = '{0, 3, 2, 0, 3, 1, 3, 2};
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // direct-mapped, 16 sets
    send(OP_FLUSH, 32'hFFFF_FFFF);
    send(OP_ACCESS, 32'h0000_0000);
    send(OP_ACCESS, 32'h0000_003F);
    send(OP_ACCESS, 32'hFFFF_FFFF);
    send(OP_ACCESS, 32'hFFFF_FFC0);
    send(OP_ACCESS, 32'h0000_0400);
    send(OP_ACCESS, 32'h0000_0000);
    send(OP_ACCESS, 32'hAAAA_AAAA);
    send(OP_ACCESS, 32'h5555_5555);
    send(OP_FLUSH, 32'h0000_0000);
    send(OP_ACCESS, 32'h0000_0000);
    wait_drained();

    // 2 sets x 4 ways, old entries kept under the new layout
    write_reg(CFG_WAYS_LOG2, 2);
    write_reg(CFG_SETS_LOG2, 1);
    send(OP_ACCESS, 32'h0000_0000);
    send(OP_ACCESS, 32'h0000_0080);
    send(OP_ACCESS, 32'h0000_0100);
    send(OP_ACCESS, 32'h0000_0180);
    send(OP_ACCESS, 32'h0000_0200);
    send(OP_ACCESS, 32'h0000_0080);
    send(OP_ACCESS, 32'h0000_0000);
    send(OP_ACCESS, 32'h0000_0100);
    wait_drained();

    // oversized geometry, clamped to 256 sets x 8 ways
    write_reg(CFG_SETS_LOG2, 11);
    write_reg(CFG_WAYS_LOG2, 3);
    send(OP_ACCESS, 32'hFFFF_FFFF);
    send(OP_ACCESS, 32'h0000_3FC0);
    send(OP_ACCESS, 32'h0000_4000);
    send(OP_ACCESS, 32'h0000_3FC0);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_SETS_LOG2, sl_list[p]);
        write_reg(CFG_WAYS_LOG2, wl_list[p]);
      end else begin
        write_reg(CFG_WAYS_LOG2, wl_list[p]);
        write_reg(CFG_SETS_LOG2, sl_list[p]);
      end
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      repeat (66) pending_words = {pending_words, random_word()};
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d words (%0d flushes), %0d results checked, %0d hits,",
             words_accepted, flushes_sent, results_seen, hits_seen);
    $display("over 11 geometries from 1 set to 2048 blocks, 1 to 8 ways, clamping included.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/salc_pkg.sv
design/salc_tag_ram.sv
design/salc_way_select.sv
design/set_assoc_lru_cache_tags_top.sv
design/salc_checker.sv
test/tb_set_assoc_lru_cache_tags_top.sv
